>>> sv/tilt_orientation_settle_defines.svh
// Assertion macros for the tilt orientation settle block.
`ifndef TILT_ORIENTATION_SETTLE_DEFINES_SVH
`define TILT_ORIENTATION_SETTLE_DEFINES_SVH
`ifndef SYNTHESIS
`define TOS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tos: same-cycle check failed");
`define TOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tos: next-cycle check failed");
`else
`define TOS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/tos_pkg.sv
// Shared types and constants for the tilt orientation settle block.
`default_nettype none
package tos_pkg;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_IMU_AVAILABLE = 3'd0;
  localparam logic [2:0] REG_START_ROT     = 3'd1;
  localparam logic [2:0] REG_SAMPLE_INT    = 3'd2;
  localparam logic [2:0] REG_SETTLE        = 3'd3;
  localparam logic [2:0] REG_MIN_AXIS      = 3'd4;
  localparam logic [2:0] REG_FLAT_MARGIN   = 3'd5;

  localparam logic [1:0] ROT_Y_NEG = 2'd0;
  localparam logic [1:0] ROT_X_NEG = 2'd1;
  localparam logic [1:0] ROT_Y_POS = 2'd2;
  localparam logic [1:0] ROT_X_POS = 2'd3;

  localparam logic [15:0] SAMPLE_INT_RST = 16'd250;
  localparam logic [15:0] SETTLE_RST     = 16'd650;
  localparam logic [14:0] MIN_AXIS_RST   = 15'd1556;
  localparam logic [14:0] FLAT_MARGIN_RST = 15'd492;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               enabled;
    logic               accel_ok;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic       rotated;
    logic [1:0] rotation;
  } out_item_t;

  typedef struct packed {
    logic        imu_available;
    logic [1:0]  start_rotation;
    logic        start_load;
    logic [15:0] sample_interval_ms;
    logic [15:0] settle_ms;
    logic [14:0] min_axis_level;
    logic [14:0] flat_margin;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] rotation;
  } cand_t;

endpackage
`default_nettype wire

>>> sv/tos_regs.sv
// APB configuration register file for the tilt orientation settle block.
`default_nettype none
module tos_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [tos_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output tos_pkg::cfg_t                  cfg
);

  logic        imu_available_r;
  logic [1:0]  start_rotation_r;
  logic [15:0] sample_interval_r;
  logic [15:0] settle_r;
  logic [14:0] min_axis_r;
  logic [14:0] flat_margin_r;
  logic        wr_en;
  logic        start_load;
  logic [2:0]  reg_idx;

  assign pready     = 1'b1;
  assign reg_idx    = paddr[4:2];
  assign wr_en      = psel & penable & pwrite;
  assign start_load = wr_en && (reg_idx == tos_pkg::REG_START_ROT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imu_available_r   <= 1'b1;
      start_rotation_r  <= tos_pkg::ROT_Y_NEG;
      sample_interval_r <= tos_pkg::SAMPLE_INT_RST;
      settle_r          <= tos_pkg::SETTLE_RST;
      min_axis_r        <= tos_pkg::MIN_AXIS_RST;
      flat_margin_r     <= tos_pkg::FLAT_MARGIN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        tos_pkg::REG_IMU_AVAILABLE: imu_available_r   <= pwdata[0];
        tos_pkg::REG_START_ROT:     start_rotation_r  <= pwdata[1:0];
        tos_pkg::REG_SAMPLE_INT:    sample_interval_r <= pwdata[15:0];
        tos_pkg::REG_SETTLE:        settle_r          <= pwdata[15:0];
        tos_pkg::REG_MIN_AXIS:      min_axis_r        <= pwdata[14:0];
        tos_pkg::REG_FLAT_MARGIN:   flat_margin_r     <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tos_pkg::REG_IMU_AVAILABLE: prdata = {31'd0, imu_available_r};
      tos_pkg::REG_START_ROT:     prdata = {30'd0, start_rotation_r};
      tos_pkg::REG_SAMPLE_INT:    prdata = {16'd0, sample_interval_r};
      tos_pkg::REG_SETTLE:        prdata = {16'd0, settle_r};
      tos_pkg::REG_MIN_AXIS:      prdata = {17'd0, min_axis_r};
      tos_pkg::REG_FLAT_MARGIN:   prdata = {17'd0, flat_margin_r};
      default:                    prdata = 32'd0;
    endcase
  end

  // during a start_rotation write the new value goes straight to the rotation state
  always_comb begin
    cfg.imu_available      = imu_available_r;
    cfg.start_rotation     = start_load ? pwdata[1:0] : start_rotation_r;
    cfg.start_load         = start_load;
    cfg.sample_interval_ms = sample_interval_r;
    cfg.settle_ms          = settle_r;
    cfg.min_axis_level     = min_axis_r;
    cfg.flat_margin        = flat_margin_r;
  end

endmodule
`default_nettype wire

>>> sv/tos_classify.sv
// Picks the candidate rotation from one accelerometer sample.
`default_nettype none
module tos_classify (
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic [14:0]        min_axis_level,
  input  wire logic [14:0]        flat_margin,
  output tos_pkg::cand_t          cand
);

  logic [16:0] ax;
  logic [16:0] ay;
  logic [16:0] az;
  logic [16:0] dom;
  logic [17:0] flat_lim;
  logic        x_wins;
  logic        x_pos;
  logic        y_pos;

  // magnitudes need 17 bits so that -32768 maps to 32768
  assign ax = accel_x[15] ? (~{1'b1, accel_x} + 17'd1) : {1'b0, accel_x};
  assign ay = accel_y[15] ? (~{1'b1, accel_y} + 17'd1) : {1'b0, accel_y};
  assign az = accel_z[15] ? (~{1'b1, accel_z} + 17'd1) : {1'b0, accel_z};

  assign x_wins   = ax > ay;
  assign dom      = x_wins ? ax : ay;
  assign flat_lim = {1'b0, dom} + {3'd0, flat_margin};
  assign x_pos    = !accel_x[15] && (accel_x != 16'sd0);
  assign y_pos    = !accel_y[15] && (accel_y != 16'sd0);

  always_comb begin
    cand.valid = (dom >= {2'd0, min_axis_level}) && ({1'b0, az} <= flat_lim);
    if (x_wins) begin
      cand.rotation = x_pos ? tos_pkg::ROT_X_POS : tos_pkg::ROT_X_NEG;
    end else begin
      cand.rotation = y_pos ? tos_pkg::ROT_Y_POS : tos_pkg::ROT_Y_NEG;
    end
  end

endmodule
`default_nettype wire

>>> sv/tilt_orientation_settle.sv
// Tilt orientation settle: display rotation from accelerometer polls, top level.
// One poll is taken per clock cycle while the result side is not stalled; each poll's
// result passes through the input register, then the result register. The
// rotation state is updated in the same cycle the poll moves from the input
// register to the result register, so consecutive polls see each other's state
// without stalls. Every poll yields exactly one result. Writing start_rotation
// also loads the current rotation; configure only while no poll is in flight.
`default_nettype none
`include "tilt_orientation_settle_defines.svh"
module tilt_orientation_settle (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire tos_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output tos_pkg::out_item_t              out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tos_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  tos_pkg::cfg_t      cfg;
  tos_pkg::cand_t     cand;
  tos_pkg::in_item_t  s1_item_r;
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  tos_pkg::out_item_t out_item_r;
  tos_pkg::out_item_t out_item_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;

  logic [1:0]  cur_rot_r;
  logic [1:0]  cur_rot_nxt;
  logic        pend_valid_r;
  logic        pend_valid_nxt;
  logic [1:0]  pend_rot_r;
  logic [1:0]  pend_rot_nxt;
  logic [31:0] pend_since_r;
  logic [31:0] pend_since_nxt;
  logic [31:0] last_time_r;
  logic [31:0] last_time_nxt;

  logic        adv;
  logic        in_xfer;
  logic [31:0] since_last;
  logic [31:0] since_pend;
  logic        too_early;

  tos_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tos_classify u_classify (
    .accel_x        (s1_item_r.accel_x),
    .accel_y        (s1_item_r.accel_y),
    .accel_z        (s1_item_r.accel_z),
    .min_axis_level (cfg.min_axis_level),
    .flat_margin    (cfg.flat_margin),
    .cand           (cand)
  );

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign since_last = s1_item_r.now_ms - last_time_r;
  assign since_pend = s1_item_r.now_ms - pend_since_r;
  assign too_early  = (last_time_r != 32'd0) &&
                      (since_last < {16'd0, cfg.sample_interval_ms});

  always_comb begin
    cur_rot_nxt    = cur_rot_r;
    pend_valid_nxt = pend_valid_r;
    pend_rot_nxt   = pend_rot_r;
    pend_since_nxt = pend_since_r;
    last_time_nxt  = last_time_r;
    out_item_nxt.rotated = 1'b0;
    if (!s1_item_r.enabled || !cfg.imu_available) begin
      pend_valid_nxt = 1'b0;
      pend_rot_nxt   = 2'd0;
      pend_since_nxt = 32'd0;
    end else if (!too_early) begin
      last_time_nxt = s1_item_r.now_ms;
      if (s1_item_r.accel_ok) begin
        if (!cand.valid || (cand.rotation == cur_rot_r)) begin
          pend_valid_nxt = 1'b0;
          pend_rot_nxt   = 2'd0;
          pend_since_nxt = 32'd0;
        end else if (!pend_valid_r || (cand.rotation != pend_rot_r)) begin
          pend_valid_nxt = 1'b1;
          pend_rot_nxt   = cand.rotation;
          pend_since_nxt = s1_item_r.now_ms;
        end else if (since_pend >= {16'd0, cfg.settle_ms}) begin
          cur_rot_nxt          = cand.rotation;
          pend_valid_nxt       = 1'b0;
          pend_rot_nxt         = 2'd0;
          pend_since_nxt       = 32'd0;
          out_item_nxt.rotated = 1'b1;
        end
      end
    end
    out_item_nxt.rotation = cur_rot_nxt;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      cur_rot_r    <= tos_pkg::ROT_Y_NEG;
      pend_valid_r <= 1'b0;
      pend_rot_r   <= 2'd0;
      pend_since_r <= 32'd0;
      last_time_r  <= 32'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg.start_load) begin
        cur_rot_r <= cfg.start_rotation;
      end else if (adv) begin
        cur_rot_r <= cur_rot_nxt;
      end
      if (adv) begin
        pend_valid_r <= pend_valid_nxt;
        pend_rot_r   <= pend_rot_nxt;
        pend_since_r <= pend_since_nxt;
        last_time_r  <= last_time_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_data;
    end
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  `TOS_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, adv, out_valid_r)
  `TOS_ASSERT_SAME(a_rotate_changes, clk, rst_n, adv && out_item_nxt.rotated,
                   out_item_nxt.rotation != cur_rot_r)
  `TOS_ASSERT_NEXT(a_no_imu_clears, clk, rst_n, adv && !cfg.imu_available, !pend_valid_r)
  `TOS_ASSERT_SAME(a_full_stall, clk, rst_n, s1_valid_r && out_valid_r && !out_ready,
                   !in_ready)

endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench for tilt_orientation_settle: poll driver, result monitor and rotation predictor.
`default_nettype none
module tb;

  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_ready;
  tos_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tos_pkg::out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tos_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  tilt_orientation_settle u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // predictor state and register copy
  logic        imu_on;
  logic [1:0]  start_rot;
  logic [15:0] interval;
  logic [15:0] settle;
  logic [14:0] min_lvl;
  logic [14:0] margin;
  logic [1:0]  cur_rot;
  logic        pend_v;
  logic [1:0]  pend_rot;
  logic [31:0] pend_since;
  logic [31:0] last_ts;

  tos_pkg::in_item_t  poll_q[$];
  tos_pkg::out_item_t rotation_due_q[$];
  int err_cnt = 0;
  int cycle_cnt = 0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int send_gap = 0;
  int sink_stall = 0;
  bit fast_src = 1'b0;
  bit fast_sink = 1'b0;
  logic [31:0] clock_ms = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic tos_pkg::cand_t axis_candidate(input logic signed [15:0] x,
                                                    input logic signed [15:0] y,
                                                    input logic signed [15:0] z);
    int ax, ay, az, dom;
    tos_pkg::cand_t c;
    ax = (x < 0) ? -int'(x) : int'(x);
    ay = (y < 0) ? -int'(y) : int'(y);
    az = (z < 0) ? -int'(z) : int'(z);
    dom = (ax > ay) ? ax : ay;
    c.valid = 1'b0;
    c.rotation = tos_pkg::ROT_Y_NEG;
    if (dom >= int'(min_lvl) && az <= dom + int'(margin)) begin
      c.valid = 1'b1;
      if (ax > ay) begin
        c.rotation = (x > 0) ? tos_pkg::ROT_X_POS : tos_pkg::ROT_X_NEG;
      end else begin
        c.rotation = (y > 0) ? tos_pkg::ROT_Y_POS : tos_pkg::ROT_Y_NEG;
      end
    end
    return c;
  endfunction

  task automatic settle_poll(input tos_pkg::in_item_t p, output tos_pkg::out_item_t r);
    logic [31:0] since_last;
    logic [31:0] held;
    tos_pkg::cand_t c;
    r.rotated = 1'b0;
    if (!p.enabled || !imu_on) begin
      pend_v = 1'b0;
    end else begin
      since_last = p.now_ms - last_ts;
      if (last_ts == 0 || since_last >= {16'd0, interval}) begin
        last_ts = p.now_ms;
        if (p.accel_ok) begin
          c = axis_candidate(p.accel_x, p.accel_y, p.accel_z);
          held = p.now_ms - pend_since;
          if (!c.valid || c.rotation == cur_rot) begin
            pend_v = 1'b0;
          end else if (!pend_v || c.rotation != pend_rot) begin
            pend_v = 1'b1;
            pend_rot = c.rotation;
            pend_since = p.now_ms;
          end else if (held >= {16'd0, settle}) begin
            cur_rot = c.rotation;
            pend_v = 1'b0;
            r.rotated = 1'b1;
          end
        end
      end
    end
    r.rotation = cur_rot;
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    err_cnt++;
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_cnt);
  endtask

  // monitor: predicts on each input transfer, checks each result transfer
  always @(posedge clk) begin : monitor
    tos_pkg::in_item_t  p;
    tos_pkg::out_item_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end else begin
      in_took <= rst_n && in_valid && in_ready;
      out_took <= rst_n && out_valid && out_ready;
      if (rst_n && in_valid && in_ready) begin
        p = in_data;
        settle_poll(p, want);
        rotation_due_q.push_back(want);
      end
      if (rst_n && out_valid && out_ready) begin
        if (rotation_due_q.size() == 0) begin
          flag_mismatch("unexpected result, rotation", out_data.rotation, -1);
        end else begin
          want = rotation_due_q.pop_front();
          if (out_data.rotated !== want.rotated) begin
            flag_mismatch("rotated", out_data.rotated, want.rotated);
          end
          if (out_data.rotation !== want.rotation) begin
            flag_mismatch("rotation", out_data.rotation, want.rotation);
          end
        end
      end
    end
  end

  // poll driver
  always @(negedge clk) begin : drive_in
    logic v_n;
    v_n = in_valid;
    if (!rst_n) begin
      v_n = 1'b0;
    end else begin
      if (in_took) begin
        v_n = 1'b0;
        if ($urandom_range(0, 19) == 0) fast_src = !fast_src;
        send_gap = fast_src ? 0 : $urandom_range(0, 8);
      end
      if (!v_n) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (poll_q.size() != 0) begin
          in_data <= poll_q.pop_front();
          v_n = 1'b1;
        end
      end
    end
    in_valid <= v_n;
  end

  // result sink with random stalls
  always @(negedge clk) begin : drive_out
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took) begin
        if ($urandom_range(0, 19) == 0) fast_sink = !fast_sink;
        sink_stall = fast_sink ? 0 : $urandom_range(0, 8);
      end
      if (sink_stall != 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_poll(input logic [31:0] now, input bit en, input bit ok,
                           input int x, input int y, input int z);
    tos_pkg::in_item_t p;
    p.now_ms = now;
    p.enabled = en;
    p.accel_ok = ok;
    p.accel_x = 16'(x);
    p.accel_y = 16'(y);
    p.accel_z = 16'(z);
    poll_q.push_back(p);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      tos_pkg::REG_IMU_AVAILABLE: imu_on = val[0];
      tos_pkg::REG_START_ROT: begin
        start_rot = val[1:0];
        cur_rot = val[1:0];
      end
      tos_pkg::REG_SAMPLE_INT: interval = val[15:0];
      tos_pkg::REG_SETTLE: settle = val[15:0];
      tos_pkg::REG_MIN_AXIS: min_lvl = val[14:0];
      tos_pkg::REG_FLAT_MARGIN: margin = val[14:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (poll_q.size() != 0 || in_valid || rotation_due_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // accelerations that favor one rotation, mostly passing the level and flat tests
  task automatic tilt_accel(input logic [1:0] rot, output int x, output int y, output int z);
    int dom, other, cap, zmag;
    dom = $urandom_range(32767, min_lvl);
    other = $urandom_range(dom, 0);
    if ($urandom_range(0, 1)) other = -other;
    cap = dom + margin;
    if (cap > 32767) cap = 32767;
    zmag = ($urandom_range(0, 5) == 0) ? $urandom_range(32767, 0) : $urandom_range(cap, 0);
    z = $urandom_range(0, 1) ? -zmag : zmag;
    if ((rot == tos_pkg::ROT_X_NEG || rot == tos_pkg::ROT_Y_NEG) &&
        $urandom_range(0, 15) == 0) dom = 32768;
    case (rot)
      tos_pkg::ROT_X_POS: begin x = dom;  y = other; end
      tos_pkg::ROT_X_NEG: begin x = -dom; y = other; end
      tos_pkg::ROT_Y_POS: begin y = dom;  x = other; end
      default:            begin y = -dom; x = other; end
    endcase
  endtask

  task automatic gen_phase(input int n);
    int cnt, kind, len, x, y, z;
    logic [1:0] rot;
    bit en, ok;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        rot = 2'($urandom_range(0, 3));
        len = $urandom_range(1, 6);
        if ($urandom_range(0, 24) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        for (int k = 0; k < len; k++) begin
          clock_ms += interval + $urandom_range(settle / 2 + 8, 0);
          tilt_accel(rot, x, y, z);
          en = ($urandom_range(0, 11) != 0);
          ok = ($urandom_range(0, 7) != 0);
          push_poll(clock_ms, en, ok, x, y, z);
          cnt++;
        end
      end else if (kind == 7) begin
        clock_ms = $urandom();
        push_poll(clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  int'($urandom_range(65535, 0)), int'($urandom_range(65535, 0)),
                  int'($urandom_range(65535, 0)));
        cnt++;
      end else if (kind == 8) begin
        clock_ms += $urandom_range(interval, 0);
        tilt_accel(2'($urandom_range(0, 3)), x, y, z);
        push_poll(clock_ms, 1'b1, 1'b1, x, y, z);
        cnt++;
      end else begin
        clock_ms += interval + $urandom_range(50, 0);
        x = $urandom_range(min_lvl, 0);
        y = $urandom_range(min_lvl, 0);
        z = $urandom_range(32767, 0);
        push_poll(clock_ms, 1'b1, 1'b1, -x, y, z);
        cnt++;
      end
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    imu_on = 1'b1;
    start_rot = tos_pkg::ROT_Y_NEG;
    interval = tos_pkg::SAMPLE_INT_RST;
    settle = tos_pkg::SETTLE_RST;
    min_lvl = tos_pkg::MIN_AXIS_RST;
    margin = tos_pkg::FLAT_MARGIN_RST;
    cur_rot = tos_pkg::ROT_Y_NEG;
    pend_v = 1'b0;
    pend_rot = tos_pkg::ROT_Y_NEG;
    pend_since = '0;
    last_ts = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed polls on reset register values
    push_poll(32'd0,    1'b1, 1'b1, 4096, 0, 0);          // first sample at time zero
    push_poll(32'd100,  1'b1, 1'b1, 4096, 0, 0);          // zero last time: not rate limited
    push_poll(32'd700,  1'b1, 1'b1, 4096, 0, 0);          // held long enough
    push_poll(32'd800,  1'b1, 1'b1, -4096, 0, 0);         // too early
    push_poll(32'd950,  1'b1, 1'b1, -4096, 0, 0);
    push_poll(32'd1200, 1'b0, 1'b1, -4096, 0, 0);         // disabled clears pending
    push_poll(32'd1450, 1'b1, 1'b1, -4096, 0, 0);
    push_poll(32'd1700, 1'b1, 1'b0, 0, 4096, 0);          // read failure keeps pending
    push_poll(32'd2100, 1'b1, 1'b1, -4096, 0, 0);
    push_poll(32'd2400, 1'b1, 1'b1, 0, 0, 4096);          // lying flat
    push_poll(32'd2700, 1'b1, 1'b1, 1555, 0, 0);          // just below level
    push_poll(32'd3000, 1'b1, 1'b1, 1556, -1556, 2048);   // tie goes to y, z at margin
    push_poll(32'd3300, 1'b1, 1'b1, 1556, -1556, 2049);   // z just over margin
    push_poll(32'd3600, 1'b1, 1'b1, -32768, 32767, -32768);
    push_poll(32'd3900, 1'b1, 1'b1, 0, 32767, 0);
    push_poll(32'd4600, 1'b1, 1'b1, 0, 32767, 0);
    push_poll(32'd4900, 1'b1, 1'b1, 32767, -32768, 32767);
    push_poll(32'hFFFF_FE00, 1'b1, 1'b1, 0, -32768, 0);
    push_poll(32'hFFFF_FF00, 1'b1, 1'b1, 4096, 0, 0);
    push_poll(32'h0000_0080, 1'b1, 1'b1, 4096, 0, 0);     // time wraps
    push_poll(32'h0000_0300, 1'b1, 1'b1, 4096, 0, 0);
    push_poll(32'd0,    1'b1, 1'b1, -4096, 0, 0);
    push_poll(32'd1,    1'b1, 1'b1, -4096, 0, 0);         // last sample at zero counts as none
    push_poll(32'hFFFF_FFFF, 1'b0, 1'b0, -1, -1, -1);
    clock_ms = 32'd1;

    for (int ph = 0; ph < 11; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          cfg_write(tos_pkg::REG_IMU_AVAILABLE, 32'd1);
          cfg_write(tos_pkg::REG_START_ROT, 32'(tos_pkg::ROT_Y_NEG));
          cfg_write(tos_pkg::REG_SAMPLE_INT, 32'd0);
          cfg_write(tos_pkg::REG_SETTLE, 32'd0);
          cfg_write(tos_pkg::REG_MIN_AXIS, 32'd0);
          cfg_write(tos_pkg::REG_FLAT_MARGIN, 32'd0);
        end
        1: begin
          cfg_write(tos_pkg::REG_IMU_AVAILABLE, 32'd1);
          cfg_write(tos_pkg::REG_START_ROT, 32'(tos_pkg::ROT_X_POS));
          cfg_write(tos_pkg::REG_SAMPLE_INT, 32'd65535);
          cfg_write(tos_pkg::REG_SETTLE, 32'd65535);
          cfg_write(tos_pkg::REG_MIN_AXIS, 32'd32767);
          cfg_write(tos_pkg::REG_FLAT_MARGIN, 32'd32767);
        end
        3: begin
          cfg_write(tos_pkg::REG_IMU_AVAILABLE, 32'd1);
          cfg_write(tos_pkg::REG_START_ROT, 32'(tos_pkg::ROT_Y_POS));
          cfg_write(tos_pkg::REG_SAMPLE_INT, 32'(tos_pkg::SAMPLE_INT_RST));
          cfg_write(tos_pkg::REG_SETTLE, 32'(tos_pkg::SETTLE_RST));
          cfg_write(tos_pkg::REG_MIN_AXIS, 32'(tos_pkg::MIN_AXIS_RST));
          cfg_write(tos_pkg::REG_FLAT_MARGIN, 32'(tos_pkg::FLAT_MARGIN_RST));
        end
        default: begin
          cfg_write(tos_pkg::REG_IMU_AVAILABLE, (ph == 2) ? 32'd0 : 32'd1);
          cfg_write(tos_pkg::REG_START_ROT, $urandom_range(3, 0));
          cfg_write(tos_pkg::REG_SAMPLE_INT, $urandom_range(400, 0));
          cfg_write(tos_pkg::REG_SETTLE, $urandom_range(1200, 0));
          cfg_write(tos_pkg::REG_MIN_AXIS, $urandom_range(8000, 0));
          cfg_write(tos_pkg::REG_FLAT_MARGIN, $urandom_range(4000, 0));
        end
      endcase
      gen_phase((ph == 2) ? 20 : 60);
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> tilt_orientation_settle.f
+incdir+sv
sv/tos_pkg.sv
sv/tos_regs.sv
sv/tos_classify.sv
sv/tilt_orientation_settle.sv
tb/tb.sv
